@@ sv/aescbc_pkg.sv @@
package aescbc_pkg;

    localparam int NUM_RK   = 15;
    localparam int RK_IDX_W = $clog2(NUM_RK);
    localparam int CFG_IDX_W = 3;

    typedef logic [127:0] t_block;
    typedef logic [RK_IDX_W-1:0] t_rk_idx;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_KEY0 = 3'd0;
    localparam t_cfg_idx CFG_KEY1 = 3'd1;
    localparam t_cfg_idx CFG_KEY2 = 3'd2;
    localparam t_cfg_idx CFG_KEY3 = 3'd3;
    localparam t_cfg_idx CFG_IV0  = 3'd4;
    localparam t_cfg_idx CFG_IV1  = 3'd5;

    localparam logic [7:0] RCON_INIT = 8'h01;
    localparam logic [7:0] GF_POLY   = 8'h1B;

    typedef struct packed {
        logic [63:0] ct_bytes_0_7;
        logic [63:0] ct_bytes_8_15;
        logic        first_block;
    } t_ct_item;

    typedef struct packed {
        logic [63:0] pt_bytes_0_7;
        logic [63:0] pt_bytes_8_15;
    } t_pt_item;

    typedef struct packed {
        logic    we;
        t_rk_idx idx;
        t_block  key;
    } t_rk_wr;

    localparam logic [7:0] FWD_SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] INV_SBOX [256] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    function automatic logic [7:0] xt(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? GF_POLY : 8'h00);
    endfunction

    function automatic logic [31:0] inv_mix_col(input logic [31:0] col);
        logic [7:0] a [4];
        logic [7:0] m2 [4];
        logic [7:0] m4 [4];
        logic [7:0] m8 [4];
        logic [7:0] g9 [4];
        logic [7:0] gb [4];
        logic [7:0] gd [4];
        logic [7:0] ge [4];
        for (int i = 0; i < 4; i++) begin
            a[i]  = col[31-8*i -: 8];
            m2[i] = xt(a[i]);
            m4[i] = xt(m2[i]);
            m8[i] = xt(m4[i]);
            g9[i] = m8[i] ^ a[i];
            gb[i] = m8[i] ^ m2[i] ^ a[i];
            gd[i] = m8[i] ^ m4[i] ^ a[i];
            ge[i] = m8[i] ^ m4[i] ^ m2[i];
        end
        return {ge[0] ^ gb[1] ^ gd[2] ^ g9[3],
                g9[0] ^ ge[1] ^ gb[2] ^ gd[3],
                gd[0] ^ g9[1] ^ ge[2] ^ gb[3],
                gb[0] ^ gd[1] ^ g9[2] ^ ge[3]};
    endfunction

    function automatic t_block inv_mix(input t_block s);
        t_block t;
        for (int c = 0; c < 4; c++) begin
            t[127-32*c -: 32] = inv_mix_col(s[127-32*c -: 32]);
        end
        return t;
    endfunction

    function automatic t_block inv_sub_shift(input t_block s);
        t_block t;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[127-8*(r+4*c) -: 8] = INV_SBOX[s[127-8*(r+4*((c-r+4)%4)) -: 8]];
            end
        end
        return t;
    endfunction

endpackage

@@ sv/aescbc_cell.sv @@
module aescbc_cell #(
    parameter bit LAST = 1'b0
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  aescbc_pkg::t_block i_state,
    input  aescbc_pkg::t_block i_chain,
    input  logic              i_key_we,
    input  aescbc_pkg::t_block i_key,
    output logic              o_valid,
    output aescbc_pkg::t_block o_state,
    output aescbc_pkg::t_block o_chain
);
    import aescbc_pkg::*;

    logic   r_valid;
    t_block r_state;
    t_block r_chain;
    t_block r_key;
    t_block n_state;
    t_block sub_shift;

    always_comb begin
        sub_shift = inv_sub_shift(i_state);
        if (LAST) begin
            n_state = sub_shift ^ r_key ^ i_chain;
        end else begin
            n_state = inv_mix(sub_shift) ^ r_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_state <= n_state;
            r_chain <= i_chain;
        end
        if (i_key_we) begin
            r_key <= i_key;
        end
    end

    assign o_valid = r_valid;
    assign o_state = r_state;
    assign o_chain = r_chain;

endmodule

@@ sv/aescbc_kexp.sv @@
module aescbc_kexp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [255:0]       i_key,
    output logic               o_busy,
    output aescbc_pkg::t_rk_wr o_wr
);
    import aescbc_pkg::*;

    logic       r_busy;
    t_rk_idx    r_cnt;
    logic [7:0] r_rc;
    t_block     r_ka;
    t_block     r_kb;
    logic [31:0] last_w;
    logic [31:0] tw;
    logic [31:0] w [4];
    t_block     n_kb;

    always_comb begin
        last_w = r_kb[31:0];
        if (!r_cnt[0]) begin
            tw = {FWD_SBOX[last_w[23:16]] ^ r_rc, FWD_SBOX[last_w[15:8]],
                  FWD_SBOX[last_w[7:0]], FWD_SBOX[last_w[31:24]]};
        end else begin
            tw = {FWD_SBOX[last_w[31:24]], FWD_SBOX[last_w[23:16]],
                  FWD_SBOX[last_w[15:8]], FWD_SBOX[last_w[7:0]]};
        end
        w[0] = r_ka[127:96] ^ tw;
        w[1] = r_ka[95:64] ^ w[0];
        w[2] = r_ka[63:32] ^ w[1];
        w[3] = r_ka[31:0] ^ w[2];
        n_kb = {w[0], w[1], w[2], w[3]};
    end

    always_comb begin
        o_wr.we  = r_busy;
        o_wr.idx = t_rk_idx'(NUM_RK - 1) - r_cnt;
        if (r_cnt == '0 || r_cnt == t_rk_idx'(NUM_RK - 1)) begin
            o_wr.key = r_ka;
        end else begin
            o_wr.key = inv_mix(r_ka);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == t_rk_idx'(NUM_RK - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_ka <= i_key[255:128];
            r_kb <= i_key[127:0];
            r_rc <= RCON_INIT;
        end else if (r_busy) begin
            r_ka <= r_kb;
            r_kb <= n_kb;
            if (!r_cnt[0]) begin
                r_rc <= xt(r_rc);
            end
        end
    end

    assign o_busy = r_busy;

endmodule

@@ sv/aes256_cbc_decrypt.sv @@
// AES-256 CBC decryption, one 128-bit block per transfer. A row of fourteen round
// cells follows a key-add input stage, and a new block can be taken in every cycle
// while the row is not stalled; apart from the key rebuild, the only backpressure is
// a stalled result, which holds the whole row. Round keys are expanded one per
// cycle by a single expansion unit: after reset and after every key register
// write the input stalls while the keys are rebuilt. Config writes are always taken
// and must be made while no block is in flight.
module aes256_cbc_decrypt (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  aescbc_pkg::t_ct_item    i_in_ct,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output aescbc_pkg::t_pt_item    o_out_pt,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  aescbc_pkg::t_cfg_idx    i_cfg_index,
    input  logic [63:0]             i_cfg_data
);
    import aescbc_pkg::*;

    logic [255:0] r_key;
    t_block       r_iv;
    t_block       r_prev_ct;
    logic         r_kstart;
    logic         n_kstart;
    t_block       r_rk0;
    logic         r_v0;
    t_block       r_s0;
    t_block       r_c0;

    logic   kx_busy;
    t_rk_wr kx_wr;
    logic   cfg_we;
    logic   en;
    logic   busy;
    logic   in_xfer;
    t_block ct;

    logic   v  [NUM_RK];
    t_block st [NUM_RK];
    t_block ch [NUM_RK];

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;
    assign busy        = r_kstart || kx_busy;
    assign en          = !(v[NUM_RK-1] && i_out_stall);
    assign o_in_stall  = !en || busy;
    assign in_xfer     = i_in_valid && !o_in_stall;
    assign ct          = {i_in_ct.ct_bytes_0_7, i_in_ct.ct_bytes_8_15};

    always_comb begin
        n_kstart = 1'b0;
        if (cfg_we) begin
            unique case (i_cfg_index)
                CFG_KEY0, CFG_KEY1, CFG_KEY2, CFG_KEY3: n_kstart = 1'b1;
                default:                                n_kstart = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key     <= '0;
            r_iv      <= '0;
            r_prev_ct <= '0;
            r_kstart  <= 1'b1;
            r_v0      <= 1'b0;
        end else begin
            r_kstart <= n_kstart;
            if (cfg_we) begin
                unique case (i_cfg_index)
                    CFG_KEY0: r_key[255:192] <= i_cfg_data;
                    CFG_KEY1: r_key[191:128] <= i_cfg_data;
                    CFG_KEY2: r_key[127:64]  <= i_cfg_data;
                    CFG_KEY3: r_key[63:0]    <= i_cfg_data;
                    CFG_IV0:  r_iv[127:64]   <= i_cfg_data;
                    CFG_IV1:  r_iv[63:0]     <= i_cfg_data;
                    default: ;
                endcase
            end
            if (in_xfer) begin
                r_prev_ct <= ct;
            end
            if (en) begin
                r_v0 <= in_xfer;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s0 <= ct ^ r_rk0;
            r_c0 <= i_in_ct.first_block ? r_iv : r_prev_ct;
        end
        if (kx_wr.we && kx_wr.idx == '0) begin
            r_rk0 <= kx_wr.key;
        end
    end

    aescbc_kexp u_kexp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_kstart),
        .i_key   (r_key),
        .o_busy  (kx_busy),
        .o_wr    (kx_wr)
    );

    assign v[0]  = r_v0;
    assign st[0] = r_s0;
    assign ch[0] = r_c0;

    for (genvar k = 1; k < NUM_RK; k++) begin : g_cell
        aescbc_cell #(
            .LAST (k == NUM_RK - 1)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_en     (en),
            .i_valid  (v[k-1]),
            .i_state  (st[k-1]),
            .i_chain  (ch[k-1]),
            .i_key_we (kx_wr.we && kx_wr.idx == t_rk_idx'(k)),
            .i_key    (kx_wr.key),
            .o_valid  (v[k]),
            .o_state  (st[k]),
            .o_chain  (ch[k])
        );
    end

    assign o_out_valid            = v[NUM_RK-1];
    assign o_out_pt.pt_bytes_0_7  = st[NUM_RK-1][127:64];
    assign o_out_pt.pt_bytes_8_15 = st[NUM_RK-1][63:0];

endmodule

@@ sv/aescbc_chk.sv @@
module aescbc_chk (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_in_stall,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input aescbc_pkg::t_pt_item o_out_pt,
    input logic                 i_cfg_valid,
    input logic                 o_cfg_ready,
    input aescbc_pkg::t_cfg_idx i_cfg_index
);
    import aescbc_pkg::*;

    // keys are rebuilt after reset
    a_stall_after_reset: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> o_in_stall && !o_out_valid)
        else $error("input open or result shown straight after reset");

    a_stall_after_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid && o_cfg_ready &&
        (i_cfg_index == CFG_KEY0 || i_cfg_index == CFG_KEY1 ||
         i_cfg_index == CFG_KEY2 || i_cfg_index == CFG_KEY3)
        |=> o_in_stall)
        else $error("input open while round keys are rebuilt");

    a_held_result_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |-> o_in_stall)
        else $error("transfer taken while result is held");

    a_result_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_pt))
        else $error("held result changed");

endmodule

bind aes256_cbc_decrypt aescbc_chk u_chk (.*);
